@@ src/hptc_pkg.sv @@
package hptc_pkg;

  // pipeline geometry
  localparam int FRONT_STAGES = 11;
  localparam int DIV_STAGES   = 64;
  localparam int TAIL_STAGES  = 6;
  localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STAGES + TAIL_STAGES;

  // stage at which the temperature result is complete
  localparam int TMC_STAGE = 6;
  localparam int TMC_DLY   = PIPE_LATENCY - TMC_STAGE;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_B   = 3'd5;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [31:0] s32_t;

endpackage

@@ src/humidity_pressure_temp_compensation_unit.sv @@
// Channel   Ports                                              Transaction
// ------    -----                                              -----------
// sample    start, busy, raw_pressure, raw_temperature,        start && !busy
//           raw_humidity
// result    done, temperature_mc, pressure_pa, humidity_mpct   done (one cycle)
// config    cfg_write, cfg_index, cfg_data                     cfg_write
//
// One sample may enter every cycle; its result reaches the ports through 81
// register stages: 11 arithmetic stages, a 64-stage radix-2 divider (one
// quotient bit per stage), then 6 tail stages of pressure and humidity work,
// the last being the output register. busy is high only during reset; rst
// clears the valid chain and the calibration registers. The receiver cannot
// stall, so the pipe always moves.
module humidity_pressure_temp_compensation_unit
  import hptc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [19:0]           raw_pressure,
  input  logic [19:0]           raw_temperature,
  input  logic [15:0]           raw_humidity,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic signed [31:0]    temperature_mc,
  output logic [31:0]           pressure_pa,
  output logic [16:0]           humidity_mpct
);

  logic [47:0] temp_coeffs, press_coeffs_a, press_coeffs_b, press_coeffs_c;
  logic [31:0] hum_coeffs_a;
  logic [39:0] hum_coeffs_b;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [7:0]         h1, h3;
  logic signed [15:0] h2, h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_coeffs[15:0];
  assign t2 = $signed(temp_coeffs[31:16]);
  assign t3 = $signed(temp_coeffs[47:32]);
  assign p1 = press_coeffs_a[15:0];
  assign p2 = $signed(press_coeffs_a[31:16]);
  assign p3 = $signed(press_coeffs_a[47:32]);
  assign p4 = $signed(press_coeffs_b[15:0]);
  assign p5 = $signed(press_coeffs_b[31:16]);
  assign p6 = $signed(press_coeffs_b[47:32]);
  assign p7 = $signed(press_coeffs_c[15:0]);
  assign p8 = $signed(press_coeffs_c[31:16]);
  assign p9 = $signed(press_coeffs_c[47:32]);
  assign h1 = hum_coeffs_a[7:0];
  assign h2 = $signed(hum_coeffs_a[23:8]);
  assign h3 = hum_coeffs_a[31:24];
  assign h4 = $signed(hum_coeffs_b[15:0]);
  assign h5 = $signed(hum_coeffs_b[31:16]);
  assign h6 = $signed(hum_coeffs_b[39:32]);

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs    <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      press_coeffs_c <= '0;
      hum_coeffs_a   <= '0;
      hum_coeffs_b   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP:    temp_coeffs    <= cfg_data[47:0];
        REG_PRESS_A: press_coeffs_a <= cfg_data[47:0];
        REG_PRESS_B: press_coeffs_b <= cfg_data[47:0];
        REG_PRESS_C: press_coeffs_c <= cfg_data[47:0];
        REG_HUM_A:   hum_coeffs_a   <= cfg_data[31:0];
        REG_HUM_B:   hum_coeffs_b   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // valid chain
  logic [PIPE_LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LATENCY-2:0], start & ~busy};
    end
  end

  assign done = vld[PIPE_LATENCY-1];

  // front stages
  logic [19:0] rp_pipe [8];
  logic [15:0] rh_pipe [6];
  s32_t               s1_ap;
  logic signed [16:0] s1_d;
  s32_t               s2_a, s2_dd;
  s32_t               s3_a, s3_bp;
  s32_t               s4_tf;
  s32_t               s5_tc5, s5_hv;
  logic signed [33:0] s5_v1;
  s64_t               s6_sq, s6_p5, s6_p2;
  s32_t               s6_y1p, s6_y2p, s6_h5v;
  s64_t               s7_v2a, s7_v1a, s7_p5, s7_p2;
  s32_t               s7_x, s7_y1, s7_y2;
  s64_t               s8_v2, s8_v1b;
  s32_t               s8_x, s8_yp;
  s64_t               s9_dvp, s9_n0;
  s32_t               s9_x, s9_y;
  s64_t               s10_dv, s10_n;
  s32_t               s10_x, s10_yh;
  logic [63:0]        s11_an, s11_ad;

  s32_t        tmc_dly [TMC_DLY];
  s32_t        xy_dly  [DIV_STAGES+1];
  logic        ng_dly  [DIV_STAGES+1];
  logic        zf_dly  [DIV_STAGES+TAIL_STAGES];

  s32_t        ta_diff;
  logic [20:0] p_raw;
  s32_t        hx_sum;

  assign ta_diff = $signed({15'b0, raw_temperature[19:3]}) - $signed({15'b0, t1, 1'b0});
  assign p_raw   = 21'd1048576 - {1'b0, rp_pipe[7]};
  assign hx_sum  = $signed({2'b0, rh_pipe[5], 14'b0}) - $signed({h4[11:0], 20'b0})
                   - s6_h5v + 32'sd16384;

  always_ff @(posedge clk) begin
    rp_pipe[0] <= raw_pressure;
    for (int k = 1; k < 8; k++) rp_pipe[k] <= rp_pipe[k-1];
    rh_pipe[0] <= raw_humidity;
    for (int k = 1; k < 6; k++) rh_pipe[k] <= rh_pipe[k-1];

    // S1..S4: fine temperature
    s1_ap  <= ta_diff * 32'(t2);
    s1_d   <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    s2_a   <= s1_ap >>> 11;
    s2_dd  <= 32'(s1_d) * 32'(s1_d);
    s3_a   <= s2_a;
    s3_bp  <= (s2_dd >>> 12) * 32'(t3);
    s4_tf  <= s3_a + (s3_bp >>> 14);

    // S5, S6: temperature result; open the pressure and humidity terms
    s5_tc5 <= s4_tf * 32'sd5 + 32'sd128;
    s5_v1  <= 34'(s4_tf) - 34'sd128000;
    s5_hv  <= s4_tf - 32'sd76800;
    tmc_dly[0] <= (s5_tc5 >>> 8) * 32'sd10;
    s6_sq  <= 64'(s5_v1) * 64'(s5_v1);
    s6_p5  <= 64'(s5_v1) * 64'(p5);
    s6_p2  <= 64'(s5_v1) * 64'(p2);
    s6_y1p <= s5_hv * 32'(h6);
    s6_y2p <= s5_hv * $signed({24'b0, h3});
    s6_h5v <= s5_hv * 32'(h5);

    s7_v2a <= s6_sq * 64'(p6);
    s7_v1a <= s6_sq * 64'(p3);
    s7_p5  <= s6_p5;
    s7_p2  <= s6_p2;
    s7_x   <= hx_sum >>> 15;
    s7_y1  <= s6_y1p >>> 10;
    s7_y2  <= (s6_y2p >>> 11) + 32'sd32768;

    s8_v2  <= s7_v2a + (s7_p5 <<< 17) + (64'(p4) <<< 35);
    s8_v1b <= (s7_v1a >>> 8) + (s7_p2 <<< 12);
    s8_x   <= s7_x;
    s8_yp  <= s7_y1 * s7_y2;

    s9_dvp <= (s8_v1b + 64'sh0000_8000_0000_0000) * $signed({48'b0, p1});
    s9_n0  <= $signed({12'b0, p_raw, 31'b0}) - s8_v2;
    s9_x   <= s8_x;
    s9_y   <= (s8_yp >>> 10) + 32'sd2097152;

    s10_dv <= s9_dvp >>> 33;
    s10_n  <= s9_n0 * 64'sd3125;
    s10_x  <= s9_x;
    s10_yh <= s9_y * 32'(h2) + 32'sd8192;

    // S11: magnitudes for the divider
    s11_an    <= s10_n[63] ? 64'(-s10_n) : 64'(s10_n);
    s11_ad    <= s10_dv[63] ? 64'(-s10_dv) : 64'(s10_dv);
    ng_dly[0] <= s10_n[63] ^ s10_dv[63];
    zf_dly[0] <= (s10_dv == 64'sd0);
    xy_dly[0] <= s10_x * (s10_yh >>> 14);

    for (int k = 1; k < TMC_DLY; k++) tmc_dly[k] <= tmc_dly[k-1];
    for (int k = 1; k <= DIV_STAGES; k++) begin
      xy_dly[k] <= xy_dly[k-1];
      ng_dly[k] <= ng_dly[k-1];
    end
    for (int k = 1; k < DIV_STAGES + TAIL_STAGES; k++) zf_dly[k] <= zf_dly[k-1];
  end

  // divider: one restoring step per stage
  logic [63:0] div_rem [DIV_STAGES];
  logic [63:0] div_nq  [DIV_STAGES];
  logic [63:0] div_den [DIV_STAGES];
  logic [63:0] rem_n   [DIV_STAGES];
  logic [63:0] nq_n    [DIV_STAGES];
  logic [63:0] den_n   [DIV_STAGES];
  logic [63:0] rin_c   [DIV_STAGES];
  logic [63:0] nin_c   [DIV_STAGES];
  logic [64:0] trial_c [DIV_STAGES];
  logic [64:0] diff_c  [DIV_STAGES];

  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      rin_c[i]   = (i == 0) ? 64'd0 : div_rem[(i == 0) ? 0 : i-1];
      nin_c[i]   = (i == 0) ? s11_an : div_nq[(i == 0) ? 0 : i-1];
      den_n[i]   = (i == 0) ? s11_ad : div_den[(i == 0) ? 0 : i-1];
      trial_c[i] = {rin_c[i], nin_c[i][63]};
      diff_c[i]  = trial_c[i] - {1'b0, den_n[i]};
      rem_n[i]   = diff_c[i][64] ? trial_c[i][63:0] : diff_c[i][63:0];
      nq_n[i]    = {nin_c[i][62:0], ~diff_c[i][64]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      div_rem[i] <= rem_n[i];
      div_nq[i]  <= nq_n[i];
      div_den[i] <= den_n[i];
    end
  end

  // tail stages
  s64_t        q_raw;
  s32_t        hs;
  s32_t        hv;
  logic [63:0] prod64;

  s64_t        q1_p;
  s32_t        q1_xy, q1_ss;
  s64_t        q2_p, q2_ps, q2_m1, q2_v2c;
  s32_t        q2_xy, q2_ssh;
  logic [63:0] q3_ll;
  logic [31:0] q3_lh, q3_hl;
  s64_t        q3_p, q3_v2c;
  logic [28:0] q3_h;
  s64_t        q4_p, q4_v1c, q4_v2;
  logic [26:0] q4_hm;
  s64_t        q5_pp;
  logic [16:0] q5_h;

  assign q_raw  = $signed(div_nq[DIV_STAGES-1]);
  assign hs     = xy_dly[DIV_STAGES] >>> 15;
  assign hv     = q2_xy - (q2_ssh >>> 4);
  assign prod64 = q3_ll + {q3_lh + q3_hl, 32'b0};

  always_ff @(posedge clk) begin
    q1_p   <= ng_dly[DIV_STAGES] ? -q_raw : q_raw;
    q1_xy  <= xy_dly[DIV_STAGES];
    q1_ss  <= hs * hs;

    q2_p   <= q1_p;
    q2_ps  <= q1_p >>> 13;
    q2_m1  <= (q1_p >>> 13) * 64'(p9);
    q2_v2c <= q1_p * 64'(p8);
    q2_xy  <= q1_xy;
    q2_ssh <= (q1_ss >>> 7) * $signed({24'b0, h1});

    // low 64 bits of m1 * ps from 32-bit partial products
    q3_ll  <= {32'b0, q2_m1[31:0]} * {32'b0, q2_ps[31:0]};
    q3_lh  <= 32'(q2_m1[31:0] * q2_ps[63:32]);
    q3_hl  <= 32'(q2_m1[63:32] * q2_ps[31:0]);
    q3_p   <= q2_p;
    q3_v2c <= q2_v2c;
    if (hv[31]) begin
      q3_h <= '0;
    end else if ($unsigned(hv) > HUM_MAX) begin
      q3_h <= HUM_MAX[28:0];
    end else begin
      q3_h <= hv[28:0];
    end

    q4_p   <= q3_p;
    q4_v1c <= $signed(prod64) >>> 25;
    q4_v2  <= q3_v2c >>> 19;
    q4_hm  <= {10'b0, q3_h[28:12]} * 27'd1000;

    q5_pp  <= ((q4_p + q4_v1c + q4_v2) >>> 8) + (64'(p7) <<< 4);
    q5_h   <= q4_hm[26:10];

    // hold zero where the divisor was zero
    pressure_pa    <= zf_dly[DIV_STAGES+TAIL_STAGES-1] ? 32'd0 : q5_pp[39:8];
    humidity_mpct  <= q5_h;
    temperature_mc <= tmc_dly[TMC_DLY-1];
  end

`ifndef NO_ASSERTIONS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without a matching sample");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (humidity_mpct <= 17'd100000))
    else $error("humidity beyond full scale");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (vld[PIPE_LATENCY-2] && zf_dly[DIV_STAGES+TAIL_STAGES-1]) |=> (pressure_pa == 32'd0))
    else $error("pressure not zero on zero divisor");
`endif

endmodule
